// ===== rtl/core/smeu_pkg.sv =====
package smeu_pkg;

  // Instruction codes carried in the action field.
  localparam logic [3:0] ACT_ADD    = 4'd0;
  localparam logic [3:0] ACT_MUL    = 4'd1;
  localparam logic [3:0] ACT_SWAP   = 4'd2;
  localparam logic [3:0] ACT_OVER   = 4'd3;
  localparam logic [3:0] ACT_DUP    = 4'd4;
  localparam logic [3:0] ACT_PUSH   = 4'd5;
  localparam logic [3:0] ACT_READ   = 4'd6;
  localparam logic [3:0] ACT_WRITE  = 4'd7;
  localparam logic [3:0] ACT_JUMPIF = 4'd8;

  // Result status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_UNDERFLOW = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW  = 2'd2;

  // Field widths of the request and result items.
  localparam int unsigned ACTION_BITS = 4;
  localparam int unsigned FIELD_BITS  = 32;

  // How the stack moves for one instruction.
  typedef enum logic [1:0] {
    STK_HOLD = 2'd0,
    STK_PUSH = 2'd1,
    STK_POP  = 2'd2,
    STK_SWAP = 2'd3
  } stk_op_t;

  typedef struct packed {
    stk_op_t    op;
    logic [1:0] status;
    logic       wr_valid;
    logic       jmp_taken;
  } smeu_ctl_t;

endpackage

// ===== rtl/core/smeu_decode.sv =====
module smeu_decode
  import smeu_pkg::*;
#(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned DW        = $clog2(DEPTH + 1)
) (
  input  logic [ACTION_BITS-1:0] action,
  input  logic [FIELD_BITS-1:0]  immediate,
  input  logic [FIELD_BITS-1:0]  read_value,
  input  logic [DW-1:0]          depth,
  input  logic [WORD_BITS-1:0]   top,
  input  logic [WORD_BITS-1:0]   sec,
  output smeu_ctl_t              ctl,
  output logic [WORD_BITS-1:0]   new_val,
  output logic [FIELD_BITS-1:0]  write_value,
  output logic [FIELD_BITS-1:0]  jump_target
);

  logic [WORD_BITS-1:0]            sum;
  logic [WORD_BITS-1:0]            prod;
  logic [WORD_BITS+FIELD_BITS-1:0] imm_ext;
  logic [WORD_BITS+FIELD_BITS-1:0] rv_ext;
  logic [WORD_BITS+FIELD_BITS-1:0] top_ext;
  logic [WORD_BITS-1:0]            imm_w;
  logic [WORD_BITS-1:0]            rv_w;
  logic                            need_one;
  logic                            need_two;
  logic                            grow;
  logic                            known;
  logic                            has_one;
  logic                            has_two;
  logic                            full;
  stk_op_t                         op_ok;
  logic [WORD_BITS-1:0]            val_ok;

  assign sum  = top + sec;
  assign prod = top * sec;

  // Words narrower than the fields take the low bits; wider ones are zero-filled.
  assign imm_ext = {{WORD_BITS{1'b0}}, immediate};
  assign rv_ext  = {{WORD_BITS{1'b0}}, read_value};
  assign top_ext = {{FIELD_BITS{1'b0}}, top};
  assign imm_w   = imm_ext[WORD_BITS-1:0];
  assign rv_w    = rv_ext[WORD_BITS-1:0];

  assign has_one = (depth >= DW'(1));
  assign has_two = (depth >= DW'(2));
  assign full    = (depth == DW'(DEPTH));

  always_comb begin
    need_one = 1'b0;
    need_two = 1'b0;
    grow     = 1'b0;
    known    = 1'b1;
    op_ok    = STK_HOLD;
    val_ok   = sec;
    case (action)
      ACT_ADD: begin
        need_two = 1'b1;
        op_ok    = STK_POP;
        val_ok   = sum;
      end
      ACT_MUL: begin
        need_two = 1'b1;
        op_ok    = STK_POP;
        val_ok   = prod;
      end
      ACT_SWAP: begin
        need_two = 1'b1;
        op_ok    = STK_SWAP;
      end
      ACT_OVER: begin
        need_two = 1'b1;
        grow     = 1'b1;
        op_ok    = STK_PUSH;
        val_ok   = sec;
      end
      ACT_DUP: begin
        need_one = 1'b1;
        grow     = 1'b1;
        op_ok    = STK_PUSH;
        val_ok   = top;
      end
      ACT_PUSH: begin
        grow   = 1'b1;
        op_ok  = STK_PUSH;
        val_ok = imm_w;
      end
      ACT_READ: begin
        grow   = 1'b1;
        op_ok  = STK_PUSH;
        val_ok = rv_w;
      end
      ACT_WRITE, ACT_JUMPIF: begin
        need_one = 1'b1;
        op_ok    = STK_POP;
        val_ok   = sec;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  always_comb begin
    ctl.status    = STAT_OK;
    ctl.op        = STK_HOLD;
    ctl.wr_valid  = 1'b0;
    ctl.jmp_taken = 1'b0;
    // Underflow takes precedence over overflow.
    if ((need_two && !has_two) || (need_one && !has_one)) begin
      ctl.status = STAT_UNDERFLOW;
    end else if (grow && full) begin
      ctl.status = STAT_OVERFLOW;
    end else if (known) begin
      ctl.op        = op_ok;
      ctl.wr_valid  = (action == ACT_WRITE);
      ctl.jmp_taken = (action == ACT_JUMPIF) && !top[WORD_BITS-1];
    end
  end

  assign new_val     = val_ok;
  assign write_value = ctl.wr_valid ? top_ext[FIELD_BITS-1:0] : '0;
  assign jump_target = ctl.jmp_taken ? immediate : '1;

endmodule

// ===== rtl/core/smeu_stack.sv =====
module smeu_stack
  import smeu_pkg::*;
#(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned DW        = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  stk_op_t              op,
  input  logic [WORD_BITS-1:0] new_val,
  output logic [WORD_BITS-1:0] top,
  output logic [WORD_BITS-1:0] sec,
  output logic [DW-1:0]        depth,
  output logic [DW-1:0]        depth_nxt
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // The top two entries live in registers; the rest sit in the memory at
  // their own stack positions. third_r always holds the entry below those two.
  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] top_r;
  logic [WORD_BITS-1:0] sec_r;
  logic [WORD_BITS-1:0] third_r;
  logic [DW-1:0]        depth_r;
  logic [DW-1:0]        depth_nxt_w;
  logic [DW-1:0]        wr_pos;
  logic [DW-1:0]        rd_pos;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr;
  logic                 mem_we;

  assign wr_pos  = depth_r - DW'(2);
  assign rd_pos  = depth_r - DW'(4);
  assign wr_addr = wr_pos[AW-1:0];
  assign rd_addr = rd_pos[AW-1:0];
  assign mem_we  = en && (op == STK_PUSH) && (depth_r >= DW'(2));

  always_comb begin
    case (op)
      STK_PUSH: depth_nxt_w = depth_r + DW'(1);
      STK_POP:  depth_nxt_w = depth_r - DW'(1);
      default:  depth_nxt_w = depth_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= sec_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (op)
        STK_PUSH: begin
          top_r   <= new_val;
          sec_r   <= top_r;
          // The spilled entry becomes the new third one.
          third_r <= sec_r;
        end
        STK_POP: begin
          top_r   <= new_val;
          sec_r   <= third_r;
          third_r <= mem[rd_addr];
        end
        STK_SWAP: begin
          top_r <= sec_r;
          sec_r <= top_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else if (en) begin
      depth_r <= depth_nxt_w;
    end
  end

  assign top       = top_r;
  assign sec       = sec_r;
  assign depth     = depth_r;
  assign depth_nxt = depth_nxt_w;

endmodule

// ===== rtl/core/stack_machine_execute_unit.sv =====
// Stack machine execute unit. Each request carries one instruction (add, mul,
// swap, over, dup, push, read, write, jumpif) and yields exactly one result with
// a status, the value popped by write, the jump decision and the new stack
// depth. One instruction is taken every clock cycle while the result side keeps
// up: the top two stack entries are held in registers and the third is
// prefetched from the stack memory, so every instruction completes in a single
// pass and its result appears in the cycle after acceptance. The critical path
// is the WORD_BITS by WORD_BITS multiplier feeding the top-of-stack register. On
// underflow or overflow the stack is left untouched. The stack memory needs no
// clearing after reset; only the depth counter and out_tvalid are reset.
module stack_machine_execute_unit
  import smeu_pkg::*;
#(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,

  input  logic                  in_tvalid,
  output logic                  in_tready,
  // action[3:0], immediate[35:4], read_value[67:36], zero padding above
  input  logic [71:0]           in_tdata,

  output logic                  out_tvalid,
  input  logic                  out_tready,
  // status[1:0], write_valid[2], write_value[34:3], jump_taken[35],
  // jump_target[67:36], stack_depth[67+DW:68], zero padding above
  output logic [((2 + 1 + FIELD_BITS + 1 + FIELD_BITS + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0]
                                out_tdata
);

  localparam int unsigned DW        = $clog2(DEPTH + 1);
  localparam int unsigned OUT_BITS  = 2 + 1 + FIELD_BITS + 1 + FIELD_BITS + DW;
  localparam int unsigned OUT_BYTES = (OUT_BITS + 7) / 8;

  logic [ACTION_BITS-1:0]  action;
  logic [FIELD_BITS-1:0]   immediate;
  logic [FIELD_BITS-1:0]   read_value;
  logic                    accept;
  smeu_ctl_t               ctl;
  logic [WORD_BITS-1:0]    new_val;
  logic [WORD_BITS-1:0]    top;
  logic [WORD_BITS-1:0]    sec;
  logic [DW-1:0]           depth;
  logic [DW-1:0]           depth_nxt;
  logic [FIELD_BITS-1:0]   write_value;
  logic [FIELD_BITS-1:0]   jump_target;
  logic                    out_valid_r;
  logic [OUT_BITS-1:0]     out_data_r;

  assign action     = in_tdata[3:0];
  assign immediate  = in_tdata[35:4];
  assign read_value = in_tdata[67:36];

  // A new request may enter whenever the result register is free or draining.
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  smeu_decode #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS),
    .DW        (DW)
  ) u_decode (
    .action      (action),
    .immediate   (immediate),
    .read_value  (read_value),
    .depth       (depth),
    .top         (top),
    .sec         (sec),
    .ctl         (ctl),
    .new_val     (new_val),
    .write_value (write_value),
    .jump_target (jump_target)
  );

  smeu_stack #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS),
    .DW        (DW)
  ) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (accept),
    .op        (ctl.op),
    .new_val   (new_val),
    .top       (top),
    .sec       (sec),
    .depth     (depth),
    .depth_nxt (depth_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {depth_nxt, jump_target, ctl.jmp_taken, write_value,
                     ctl.wr_valid, ctl.status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = (OUT_BYTES * 8)'(out_data_r);

endmodule

// ===== tb/tb_stack_machine_execute_unit.sv =====
module tb_stack_machine_execute_unit;
  import smeu_pkg::*;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned DEPTH_BITS  = 7;
  localparam int unsigned OUT_BITS    = 80;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASE_ONE_END  = 620;
  localparam int unsigned PHASE_TWO_END  = 1240;
  localparam int unsigned HOLD_AT        = 1500;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned RANDOM_ITEMS   = 1850;
  localparam int unsigned TAIL_CYCLES    = 8;

  // Codes above jumpif are not instructions and leave the stack alone.
  localparam logic [3:0] ACT_UNUSED_FIRST = ACT_JUMPIF + 4'd1;
  localparam logic [3:0] ACT_UNUSED_LAST  = 4'hF;

  localparam logic [3:0] GROW_OPS [4]   = '{ACT_OVER, ACT_DUP, ACT_PUSH, ACT_READ};
  localparam logic [3:0] SHRINK_OPS [4] = '{ACT_ADD, ACT_MUL, ACT_WRITE, ACT_JUMPIF};
  localparam logic [31:0] EDGE_VALUES [5] = '{32'h0, 32'h1, 32'h7FFF_FFFF,
                                              32'h8000_0000, 32'hFFFF_FFFF};

  typedef struct {
    logic [3:0]  act;
    logic [31:0] imm;
    logic [31:0] rv;
    bit          drain_first;
  } instr_t;

  typedef struct packed {
    logic [1:0]            status;
    logic                  wr_valid;
    logic [31:0]           wr_value;
    logic                  jmp_taken;
    logic [31:0]           jmp_target;
    logic [DEPTH_BITS-1:0] depth;
  } stack_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [71:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_BITS-1:0] out_tdata;

  instr_t instr_queue[$];
  stack_result_t predicted_results[$];
  instr_t cur_instr;
  stack_result_t next_result;

  // Private copy of the stack that the predictor walks alongside the block.
  logic [31:0] stack_copy [STACK_DEPTH];
  logic [DEPTH_BITS-1:0] stack_level = '0;

  int unsigned items_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned error_count = 0;
  int unsigned underflow_count = 0;
  int unsigned overflow_count = 0;
  int unsigned jump_count = 0;
  int unsigned write_count = 0;
  int unsigned deepest = 0;
  int unsigned hold_left = 0;
  bit hold_done = 1'b0;
  int unsigned quiet_cycles = 0;

  stack_machine_execute_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned send_idle_pct();
    if (items_accepted < PHASE_ONE_END) return 15;
    if (items_accepted < PHASE_TWO_END) return 88;
    return 0;
  endfunction

  function automatic int unsigned recv_idle_pct();
    if (items_accepted < PHASE_ONE_END) return 88;
    if (items_accepted < PHASE_TWO_END) return 15;
    return 0;
  endfunction

  // Executes one instruction on the private stack and returns its result.
  task automatic execute_instr(input instr_t ins, output stack_result_t res);
    int unsigned need;
    int unsigned grow;
    logic [31:0] top;
    logic [31:0] second;
    need = 0;
    grow = 0;
    top = '0;
    second = '0;
    res.status = STAT_OK;
    res.wr_valid = 1'b0;
    res.wr_value = '0;
    res.jmp_taken = 1'b0;
    res.jmp_target = '1;
    case (ins.act)
      ACT_ADD, ACT_MUL, ACT_SWAP, ACT_OVER: need = 2;
      ACT_DUP, ACT_WRITE, ACT_JUMPIF: need = 1;
      default: need = 0;
    endcase
    if (ins.act == ACT_OVER || ins.act == ACT_DUP || ins.act == ACT_PUSH ||
        ins.act == ACT_READ)
      grow = 1;
    if (ins.act <= ACT_JUMPIF) begin
      if (stack_level < need) begin
        res.status = STAT_UNDERFLOW;
        underflow_count++;
      end else if (stack_level + grow > STACK_DEPTH) begin
        res.status = STAT_OVERFLOW;
        overflow_count++;
      end else begin
        if (stack_level >= 1) top = stack_copy[stack_level - 1];
        if (stack_level >= 2) second = stack_copy[stack_level - 2];
        case (ins.act)
          ACT_ADD: begin
            stack_copy[stack_level - 2] = top + second;
            stack_level--;
          end
          ACT_MUL: begin
            stack_copy[stack_level - 2] = top * second;
            stack_level--;
          end
          ACT_SWAP: begin
            stack_copy[stack_level - 1] = second;
            stack_copy[stack_level - 2] = top;
          end
          ACT_OVER: begin
            stack_copy[stack_level] = second;
            stack_level++;
          end
          ACT_DUP: begin
            stack_copy[stack_level] = top;
            stack_level++;
          end
          ACT_PUSH: begin
            stack_copy[stack_level] = ins.imm;
            stack_level++;
          end
          ACT_READ: begin
            stack_copy[stack_level] = ins.rv;
            stack_level++;
          end
          ACT_WRITE: begin
            res.wr_valid = 1'b1;
            res.wr_value = top;
            write_count++;
            stack_level--;
          end
          default: begin
            if (!top[31]) begin
              res.jmp_taken = 1'b1;
              res.jmp_target = ins.imm;
              jump_count++;
            end
            stack_level--;
          end
        endcase
      end
    end
    res.depth = stack_level;
    if (stack_level > deepest) deepest = stack_level;
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR: result %0d field %s is %h, expected %h", results_checked, field,
             got, want);
    error_count++;
  endtask

  task automatic queue_instr(input logic [3:0] act, input logic [31:0] imm,
                             input logic [31:0] rv, input bit drain_first);
    instr_t ins;
    ins.act = act;
    ins.imm = imm;
    ins.rv = rv;
    ins.drain_first = drain_first;
    instr_queue.push_back(ins);
  endtask

  function automatic logic [31:0] pick_value();
    if ($urandom_range(7) == 0) return EDGE_VALUES[$urandom_range(4)];
    return $urandom;
  endfunction

  // Driver: presents queued requests and predicts each one as it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        execute_instr(cur_instr, next_result);
        predicted_results.push_back(next_result);
        items_accepted <= items_accepted + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (instr_queue.size() != 0 && $urandom_range(99) >= send_idle_pct() &&
            (!instr_queue[0].drain_first || predicted_results.size() == 0)) begin
          cur_instr = instr_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {4'b0, cur_instr.rv, cur_instr.imm, cur_instr.act};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off that fills the block.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (!hold_done && items_accepted >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct());
      end
    end
  end

  // Monitor: compares every accepted result with the oldest prediction.
  always @(posedge clk) begin
    stack_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (predicted_results.size() == 0) begin
        $display("ERROR: result arrived with no instruction outstanding");
        error_count++;
      end else begin
        want = predicted_results.pop_front();
        if (out_tdata[1:0] !== want.status)
          report_mismatch("status", out_tdata[1:0], want.status);
        if (out_tdata[2] !== want.wr_valid)
          report_mismatch("write_valid", out_tdata[2], want.wr_valid);
        if (out_tdata[34:3] !== want.wr_value)
          report_mismatch("write_value", out_tdata[34:3], want.wr_value);
        if (out_tdata[35] !== want.jmp_taken)
          report_mismatch("jump_taken", out_tdata[35], want.jmp_taken);
        if (out_tdata[67:36] !== want.jmp_target)
          report_mismatch("jump_target", out_tdata[67:36], want.jmp_target);
        if (out_tdata[74:68] !== want.depth)
          report_mismatch("stack_depth", out_tdata[74:68], want.depth);
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    bit filling;
    int unsigned run_left;
    int unsigned pick;
    logic [3:0] act;

    // Directed: errors on an empty or shallow stack, wrapping arithmetic,
    // both jump outcomes and unused action codes.
    queue_instr(ACT_WRITE, 32'h0, 32'h0, 1'b0);
    queue_instr(ACT_JUMPIF, 32'h5, 32'h0, 1'b0);
    queue_instr(ACT_DUP, 32'h0, 32'h0, 1'b0);
    queue_instr(ACT_ADD, 32'h0, 32'h0, 1'b0);
    queue_instr(ACT_UNUSED_FIRST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_instr(ACT_PUSH, 32'h7FFF_FFFF, 32'h0, 1'b0);
    queue_instr(ACT_ADD, 32'h0, 32'h0, 1'b0);
    queue_instr(ACT_OVER, 32'h0, 32'h0, 1'b0);
    queue_instr(ACT_PUSH, 32'h8000_0000, 32'h0, 1'b0);
    queue_instr(ACT_ADD, 32'h0, 32'h0, 1'b0);
    queue_instr(ACT_PUSH, 32'h7FFF_FFFF, 32'h0, 1'b0);
    queue_instr(ACT_MUL, 32'h0, 32'h0, 1'b0);
    queue_instr(ACT_READ, 32'h0, 32'h8000_0000, 1'b0);
    queue_instr(ACT_SWAP, 32'h0, 32'h0, 1'b0);
    queue_instr(ACT_OVER, 32'h0, 32'h0, 1'b0);
    queue_instr(ACT_DUP, 32'h0, 32'h0, 1'b0);
    queue_instr(ACT_MUL, 32'h0, 32'h0, 1'b0);
    queue_instr(ACT_PUSH, 32'h0, 32'h0, 1'b0);
    queue_instr(ACT_JUMPIF, 32'h7FFF_FFFF, 32'h0, 1'b0);
    queue_instr(ACT_READ, 32'h0, 32'hFFFF_FFFF, 1'b0);
    queue_instr(ACT_JUMPIF, 32'h8000_0000, 32'h0, 1'b0);
    queue_instr(ACT_WRITE, 32'h0, 32'h0, 1'b0);
    queue_instr(ACT_UNUSED_LAST, 32'h0, 32'h0, 1'b0);
    queue_instr(ACT_WRITE, 32'h0, 32'h0, 1'b0);
    queue_instr(ACT_WRITE, 32'h0, 32'h0, 1'b0);

    // Random part: runs that mostly grow the stack alternate with runs that
    // mostly shrink it, so the depth keeps sweeping between empty and full.
    filling = 1'b1;
    run_left = 0;
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(200, 60);
        filling = !filling || (n == 0);
      end
      run_left--;
      pick = $urandom_range(99);
      if (pick < 3)
        act = 4'($urandom_range(ACT_UNUSED_LAST, ACT_UNUSED_FIRST));
      else if (pick < 8)
        act = ACT_SWAP;
      else if ((pick < 70) == filling)
        act = GROW_OPS[$urandom_range(3)];
      else
        act = SHRINK_OPS[$urandom_range(3)];
      queue_instr(act, pick_value(), pick_value(), (n == 0) || (n == 1300));
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (instr_queue.size() != 0 || in_tvalid) @(posedge clk);
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Executed %0d instructions and checked %0d results; stack depth reached %0d.",
             items_accepted, results_checked, deepest);
    $display("Seen: %0d underflows, %0d overflows, %0d writes, %0d taken jumps.",
             underflow_count, overflow_count, write_count, jump_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/smeu_pkg.sv
rtl/core/smeu_decode.sv
rtl/core/smeu_stack.sv
rtl/core/stack_machine_execute_unit.sv
tb/tb_stack_machine_execute_unit.sv
